@@ hdl/ggax_pkg.sv @@
// Shared types, constants and slot map for the GGA field extractor.
// Used by ggax_store, ggax_extract, the top level and the checker.
package ggax_pkg;

  localparam int unsigned FIELD_CHAR_WRAP  = 15;
  localparam int unsigned FIELD_INDEX_WRAP = 23;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_A     = 8'h41;

  // kept character slots: only the field characters the result reads
  localparam int unsigned F0_BASE   = 0;
  localparam int unsigned F1_BASE   = 6;
  localparam int unsigned F2_BASE   = 12;
  localparam int unsigned F3_BASE   = 21;
  localparam int unsigned F4_BASE   = 22;
  localparam int unsigned F5_BASE   = 32;
  localparam int unsigned F6_BASE   = 33;
  localparam int unsigned F7_BASE   = 34;
  localparam int unsigned NUM_SLOTS = 36;

  localparam int unsigned DATA_W = 216;

  typedef logic [NUM_SLOTS-1:0][7:0] slots_t;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } in_word_t;

  typedef struct packed {
    logic [15:0] satellite_chars;
    logic [7:0]  fix_quality;
    logic [7:0]  east_west;
    logic [15:0] lon_tail;
    logic [63:0] lon_head;
    logic [7:0]  north_south;
    logic [7:0]  lat_tail;
    logic [63:0] lat_head;
    logic [7:0]  utc_second;
    logic [7:0]  utc_minute;
    logic [7:0]  utc_hour;
  } result_t;

  function automatic logic [4:0] slot_field(int unsigned i);
    logic [4:0] f;
    if (i < F1_BASE) f = 5'd0;
    else if (i < F2_BASE) f = 5'd1;
    else if (i < F3_BASE) f = 5'd2;
    else if (i < F4_BASE) f = 5'd3;
    else if (i < F5_BASE) f = 5'd4;
    else if (i < F6_BASE) f = 5'd5;
    else if (i < F7_BASE) f = 5'd6;
    else f = 5'd7;
    return f;
  endfunction

  function automatic logic [3:0] slot_char(int unsigned i);
    int unsigned b;
    if (i < F1_BASE) b = F0_BASE;
    else if (i < F2_BASE) b = F1_BASE;
    else if (i < F3_BASE) b = F2_BASE;
    else if (i < F4_BASE) b = F3_BASE;
    else if (i < F5_BASE) b = F4_BASE;
    else if (i < F6_BASE) b = F5_BASE;
    else if (i < F7_BASE) b = F6_BASE;
    else b = F7_BASE;
    return 4'(i - b);
  endfunction

endpackage

@@ hdl/ggax_store.sv @@
// Field and character counters plus the kept character slots.
// Depends on ggax_pkg for the slot map and character codes.
module ggax_store (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  ggax_pkg::in_word_t word,
  output ggax_pkg::slots_t slots_next
);

  logic [4:0]       fn;
  logic [3:0]       cp;
  ggax_pkg::slots_t slots;
  logic [4:0]       fn_next;
  logic [3:0]       cp_next;
  logic             is_comma;
  logic             is_cr;
  logic [7:0]       wr_val;

  assign is_comma = (word.data == ggax_pkg::CHAR_COMMA);
  assign is_cr    = (word.data == ggax_pkg::CHAR_CR);
  assign wr_val   = (is_comma || is_cr) ? 8'd0 : word.data;

  always_comb begin
    fn_next = fn;
    cp_next = cp;
    if (is_comma) begin
      fn_next = (fn == 5'(ggax_pkg::FIELD_INDEX_WRAP - 1)) ? 5'd0 : fn + 5'd1;
      cp_next = 4'd0;
    end else if (!is_cr) begin
      cp_next = (cp == 4'(ggax_pkg::FIELD_CHAR_WRAP - 1)) ? 4'd0 : cp + 4'd1;
    end
  end

  for (genvar i = 0; i < ggax_pkg::NUM_SLOTS; i++) begin : g_slot
    localparam logic [4:0] SF = ggax_pkg::slot_field(i);
    localparam logic [3:0] SC = ggax_pkg::slot_char(i);
    logic hit_main;
    logic hit_extra;
    assign hit_main  = en && (fn == SF) && (cp == SC);
    assign hit_extra = en && is_comma && (cp == 4'd0) && (fn == SF) && (SC == 4'd1);
    assign slots_next[i] = hit_main ? wr_val : (hit_extra ? 8'd0 : slots[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fn    <= '0;
      cp    <= '0;
      slots <= '0;
    end else if (en) begin
      if (word.last) begin
        fn    <= '0;
        cp    <= '0;
        slots <= '0;
      end else begin
        fn    <= fn_next;
        cp    <= cp_next;
        slots <= slots_next;
      end
    end
  end

endmodule

@@ hdl/ggax_extract.sv @@
// Result decode from the kept slots: tag match, UTC digits, masked fields.
// Depends on ggax_pkg for the slot map, codes and result type.
module ggax_extract (
  input  ggax_pkg::slots_t slots,
  output logic             is_gga,
  output ggax_pkg::result_t result
);

  logic [8:0][7:0] lat_c;
  logic [9:0][7:0] lon_c;
  logic [1:0][7:0] sat_c;
  logic [7:0]      hour;
  logic [7:0]      minute;
  logic [7:0]      second;

  function automatic logic [7:0] two_digits(logic [7:0] hi, logic [7:0] lo);
    return 8'((hi - ggax_pkg::CHAR_ZERO) * 8'd10) + (lo - ggax_pkg::CHAR_ZERO);
  endfunction

  assign is_gga = (slots[ggax_pkg::F0_BASE + 0] == ggax_pkg::CHAR_G)
               && (slots[ggax_pkg::F0_BASE + 1] == ggax_pkg::CHAR_P)
               && (slots[ggax_pkg::F0_BASE + 2] == ggax_pkg::CHAR_G)
               && (slots[ggax_pkg::F0_BASE + 3] == ggax_pkg::CHAR_G)
               && (slots[ggax_pkg::F0_BASE + 4] == ggax_pkg::CHAR_A)
               && (slots[ggax_pkg::F0_BASE + 5] == 8'd0);

  assign hour   = two_digits(slots[ggax_pkg::F1_BASE + 0], slots[ggax_pkg::F1_BASE + 1]);
  assign minute = two_digits(slots[ggax_pkg::F1_BASE + 2], slots[ggax_pkg::F1_BASE + 3]);
  assign second = two_digits(slots[ggax_pkg::F1_BASE + 4], slots[ggax_pkg::F1_BASE + 5]);

  // zero every character after the first terminator of the field
  always_comb begin
    logic alive;
    alive = 1'b1;
    for (int k = 0; k < 9; k++) begin
      lat_c[k] = alive ? slots[ggax_pkg::F2_BASE + k] : 8'd0;
      if (slots[ggax_pkg::F2_BASE + k] == 8'd0) alive = 1'b0;
    end
    alive = 1'b1;
    for (int k = 0; k < 10; k++) begin
      lon_c[k] = alive ? slots[ggax_pkg::F4_BASE + k] : 8'd0;
      if (slots[ggax_pkg::F4_BASE + k] == 8'd0) alive = 1'b0;
    end
    sat_c[0] = slots[ggax_pkg::F7_BASE];
    sat_c[1] = (slots[ggax_pkg::F7_BASE] == 8'd0) ? 8'd0 : slots[ggax_pkg::F7_BASE + 1];
  end

  always_comb begin
    result = '0;
    if (is_gga) begin
      result.utc_hour        = hour;
      result.utc_minute      = minute;
      result.utc_second      = second;
      result.lat_head        = {lat_c[0], lat_c[1], lat_c[2], lat_c[3],
                                lat_c[4], lat_c[5], lat_c[6], lat_c[7]};
      result.lat_tail        = lat_c[8];
      result.north_south     = slots[ggax_pkg::F3_BASE];
      result.lon_head        = {lon_c[0], lon_c[1], lon_c[2], lon_c[3],
                                lon_c[4], lon_c[5], lon_c[6], lon_c[7]};
      result.lon_tail        = {lon_c[8], lon_c[9]};
      result.east_west       = slots[ggax_pkg::F5_BASE];
      result.fix_quality     = slots[ggax_pkg::F6_BASE];
      result.satellite_chars = {sat_c[0], sat_c[1]};
    end
  end

endmodule

@@ hdl/nmea_gga_field_extractor.sv @@
// Top level of the GGA field extractor: input register, store, result register.
// Depends on ggax_pkg, ggax_store and ggax_extract.
//
// Takes one sentence character per cycle on the s_ side, while s_tready is high,
// and returns one decoded GGA result on the m_ side for each word marked with
// tlast. Each word is held in the input register and applied to the field store
// from there; a last word loads the result register at the same edge as it is
// applied to the store. Non-last words keep flowing while a result waits;
// s_tready drops only while a last word is held behind a result not yet taken.
// The field store is cleared with each result.
module nmea_gga_field_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // end_of_sentence
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [ggax_pkg::DATA_W-1:0] m_tdata, // utc_hour, utc_minute, utc_second,
                                               // lat_head, lat_tail, north_south,
                                               // lon_head, lon_tail, east_west,
                                               // fix_quality, satellite_chars
  output logic        m_tuser    // is_gga
);

  logic               in_valid;
  ggax_pkg::in_word_t in_word;
  logic               process;
  ggax_pkg::slots_t   slots_next;
  logic               is_gga;
  ggax_pkg::result_t  result;

  assign process  = in_valid && (!in_word.last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || process;

  ggax_store u_store (
    .clk        (clk),
    .rst        (rst),
    .en         (process),
    .word       (in_word),
    .slots_next (slots_next)
  );

  ggax_extract u_extract (
    .slots  (slots_next),
    .is_gga (is_gga),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (process && in_word.last) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_word <= '{last: s_tlast, data: s_tdata};
    if (process && in_word.last) begin
      m_tdata <= result;
      m_tuser <= is_gga;
    end
  end

endmodule

@@ hdl/ggax_checker.sv @@
// Port-level checks for the GGA field extractor, bound to the top level.
// Depends on ggax_pkg for the result width.
module ggax_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ggax_pkg::DATA_W-1:0]   m_tdata,
  input logic                          m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  a_not_gga_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("non-GGA result carries field data");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !m_tvalid |-> s_tready)
    else $error("input stalled with no result pending");

endmodule

bind nmea_gga_field_extractor ggax_checker u_checker (.*);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for nmea_gga_field_extractor: streams sentence bytes,
// predicts each decoded GGA result in a scoreboard class and checks every word.
// Depends on ggax_pkg and the RTL of the extractor.
module tb_top;

  localparam int RANDOM_WORDS = 1950;
  localparam int QUIET_WORDS  = 1750;
  localparam int DRAIN_WORDS  = 900;
  localparam int IDLE_LIMIT   = 5000;
  localparam int KEPT_FIELDS  = 8;

  typedef struct {
    logic              is_gga;
    ggax_pkg::result_t fix;
  } gga_fix_t;

  class gga_scoreboard;
    bit [4:0]  field_idx;
    bit [3:0]  char_idx;
    bit [7:0]  field_chars [KEPT_FIELDS][ggax_pkg::FIELD_CHAR_WRAP];
    gga_fix_t  pending_fixes [$];
    int        errors;

    function new();
      errors = 0;
      clear_sentence();
    endfunction

    function void clear_sentence();
      field_idx = 0;
      char_idx  = 0;
      foreach (field_chars[f, c]) field_chars[f][c] = 8'h00;
    endfunction

    function bit [7:0] char_at(int f, int c);
      if (f >= KEPT_FIELDS || c >= ggax_pkg::FIELD_CHAR_WRAP) return 8'h00;
      return field_chars[f][c];
    endfunction

    function void put_char(int f, int c, bit [7:0] v);
      if (f < KEPT_FIELDS && c < ggax_pkg::FIELD_CHAR_WRAP) field_chars[f][c] = v;
    endfunction

    // characters first..first+n-1 of a field, zero after its first terminator
    function bit [63:0] field_text(int f, int first, int n);
      bit [63:0] acc;
      bit [7:0]  ch;
      bit        ended;
      acc   = '0;
      ended = 1'b0;
      for (int i = 0; i < first + n; i++) begin
        ch = ended ? 8'h00 : char_at(f, i);
        if (ch == 8'h00) ended = 1'b1;
        if (i >= first) acc = {acc[55:0], ch};
      end
      return acc;
    endfunction

    function bit [7:0] utc_pair(int c);
      int unsigned v;
      v = (char_at(1, c) + 208) * 10 + char_at(1, c + 1) + 208;
      return v[7:0];
    endfunction

    function void note_word(bit [7:0] b, bit last);
      gga_fix_t  x;
      bit        match;
      bit [7:0]  tag [5];
      tag = '{ggax_pkg::CHAR_G, ggax_pkg::CHAR_P, ggax_pkg::CHAR_G, ggax_pkg::CHAR_G,
              ggax_pkg::CHAR_A};
      if (b == ggax_pkg::CHAR_COMMA) begin
        if (char_idx == 0) begin
          put_char(field_idx, 0, 8'h00);
          char_idx = 1;
        end
        put_char(field_idx, char_idx, 8'h00);
        field_idx++;
        char_idx = 0;
        if (field_idx >= ggax_pkg::FIELD_INDEX_WRAP) field_idx = 0;
      end else if (b == ggax_pkg::CHAR_CR) begin
        put_char(field_idx, char_idx, 8'h00);
      end else begin
        put_char(field_idx, char_idx, b);
        char_idx++;
        if (char_idx >= ggax_pkg::FIELD_CHAR_WRAP) char_idx = 0;
      end
      if (!last) return;
      match = 1'b1;
      for (int i = 0; i < 5; i++) if (char_at(0, i) != tag[i]) match = 1'b0;
      if (char_at(0, 5) != 8'h00) match = 1'b0;
      x.is_gga = match;
      x.fix    = '0;
      if (match) begin
        x.fix.utc_hour        = utc_pair(0);
        x.fix.utc_minute      = utc_pair(2);
        x.fix.utc_second      = utc_pair(4);
        x.fix.lat_head        = field_text(2, 0, 8);
        x.fix.lat_tail        = field_text(2, 8, 1);
        x.fix.north_south     = field_text(3, 0, 1);
        x.fix.lon_head        = field_text(4, 0, 8);
        x.fix.lon_tail        = field_text(4, 8, 2);
        x.fix.east_west       = field_text(5, 0, 1);
        x.fix.fix_quality     = field_text(6, 0, 1);
        x.fix.satellite_chars = field_text(7, 0, 2);
      end
      pending_fixes.push_back(x);
      clear_sentence();
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, want, seen);
      end
    endfunction

    function void check_result(logic user, logic [ggax_pkg::DATA_W-1:0] data);
      gga_fix_t          x;
      ggax_pkg::result_t got;
      got = ggax_pkg::result_t'(data);
      if (pending_fixes.size() == 0) begin
        errors++;
        $display("%0t: result with no sentence pending, expected none actual %h",
                 $time, data);
        return;
      end
      x = pending_fixes.pop_front();
      compare("is_gga", x.is_gga, user);
      compare("utc_hour", x.fix.utc_hour, got.utc_hour);
      compare("utc_minute", x.fix.utc_minute, got.utc_minute);
      compare("utc_second", x.fix.utc_second, got.utc_second);
      compare("lat_head", x.fix.lat_head, got.lat_head);
      compare("lat_tail", x.fix.lat_tail, got.lat_tail);
      compare("north_south", x.fix.north_south, got.north_south);
      compare("lon_head", x.fix.lon_head, got.lon_head);
      compare("lon_tail", x.fix.lon_tail, got.lon_tail);
      compare("east_west", x.fix.east_west, got.east_west);
      compare("fix_quality", x.fix.fix_quality, got.fix_quality);
      compare("satellite_chars", x.fix.satellite_chars, got.satellite_chars);
    endfunction
  endclass

  logic                        clk;
  logic                        rst      = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [7:0]                  s_tdata  = 8'h00;  // data_byte
  logic                        s_tlast  = 1'b0;   // end_of_sentence
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [ggax_pkg::DATA_W-1:0] m_tdata;  // utc_hour, utc_minute, utc_second, lat_head,
                                         // lat_tail, north_south, lon_head, lon_tail,
                                         // east_west, fix_quality, satellite_chars
  logic                        m_tuser;  // is_gga

  gga_scoreboard sb;
  bit [7:0]      sentence_q [$];
  int            words_sent  = 0;
  int            idle_cycles = 0;
  int            stall_left  = 0;
  bit            quiet       = 1'b0;
  bit            gap_mode    = 1'b1;
  bit            stall_mode  = 1'b1;

  nmea_gga_field_extractor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_word(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end
  end

  // hold off the result side in short bursts
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode = !stall_mode;
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!quiet && stall_mode && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 8);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [7:0] d, input logic l);
    if (gap_mode && !quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  task automatic send_sentence();
    for (int i = 0; i < sentence_q.size(); i++)
      send_word(sentence_q[i], i == sentence_q.size() - 1);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_fixes.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) sentence_q.push_back(s[i]);
  endfunction

  function automatic bit [7:0] field_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return ggax_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
    if (r < 75) return ggax_pkg::CHAR_A + 8'($urandom_range(0, 25));
    if (r < 80) return 8'h2E;
    if (r < 83) return 8'h00;
    if (r < 86) return ggax_pkg::CHAR_CR;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void make_sentence();
    int natural_len [KEPT_FIELDS];
    int nf;
    int len;
    int r;
    natural_len = '{5, 6, 9, 1, 10, 1, 1, 2};
    sentence_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 40)) sentence_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    push_text("GPGGA");
    r = $urandom_range(0, 19);
    if (r == 0) sentence_q[$urandom_range(0, 4)] = 8'($urandom_range(0, 255));
    else if (r == 1) void'(sentence_q.pop_back());
    else if (r == 2) sentence_q.push_back(field_char());
    else if (r == 3) begin
      sentence_q.delete();
      repeat ($urandom_range(0, 6)) sentence_q.push_back(field_char());
    end
    nf = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
    for (int f = 1; f <= nf; f++) begin
      sentence_q.push_back(ggax_pkg::CHAR_COMMA);
      if (f < KEPT_FIELDS && $urandom_range(0, 4) != 0) len = natural_len[f];
      else len = $urandom_range(0, 17);
      repeat (len) sentence_q.push_back(field_char());
    end
    r = $urandom_range(0, 9);
    if (r < 6) sentence_q.push_back(ggax_pkg::CHAR_CR);
    else if (r < 8) begin
      sentence_q.push_back(ggax_pkg::CHAR_CR);
      sentence_q.push_back(8'h0A);
    end
    if (sentence_q.size() == 0) sentence_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  initial begin
    int  random_start;
    bit  drained;
    sb = new();
    drained = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    sentence_q = '{8'h00};
    send_sentence();
    sentence_q = '{8'hFF};
    send_sentence();
    sentence_q = '{ggax_pkg::CHAR_COMMA};
    send_sentence();
    sentence_q.delete();
    push_text("GPGGA,9");
    sentence_q.push_back(ggax_pkg::CHAR_CR);
    send_sentence();
    sentence_q.delete();
    push_text("GPGGA,,,N,,W,1,0");
    send_sentence();

    random_start = words_sent;
    while (words_sent - random_start < RANDOM_WORDS) begin
      if (!drained && words_sent - random_start > DRAIN_WORDS) begin
        wait_drained();
        drained = 1'b1;
      end
      quiet = (words_sent - random_start > QUIET_WORDS);
      if ($urandom_range(0, 5) == 0) gap_mode = !gap_mode;
      make_sentence();
      send_sentence();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_fixes.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
